@@ sv/software_timer_bank_macros.svh @@
// Assertion helpers for the checker file of the timer bank.
// Each macro produces one labelled concurrent assertion on the rising clock edge,
// which is switched off while reset is high.
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/stb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank package
// Transaction types, command codes and the layout of one timer entry.
// ----------------------------------------------------------------------------

package stb_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int RSP_CNT_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [15:0] TICK_DEFAULT = 16'd10;

   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_SET     = 3'd1;
   localparam logic [2:0] OP_KILL    = 3'd2;
   localparam logic [2:0] OP_RESTART = 3'd3;
   localparam logic [2:0] OP_POLL    = 3'd4;

   localparam logic RSP_STATUS = 1'b0;
   localparam logic RSP_EVENT  = 1'b1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [4:0]  channel;
      logic [15:0] tick_amount;
      logic [31:0] period;
      logic        has_handler;
   } req_type;

   typedef struct packed {
      logic       reply_kind;
      logic       success;
      logic [4:0] which_timer;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        active;
      logic        handler;
      logic        flag;
      logic [31:0] elapsed;
      logic [31:0] timeout;
   } tmr_entry_type;

endpackage

@@ sv/software_timer_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer bank
// A bank of periodic timers held in one synchronous memory, driven by commands.
// ----------------------------------------------------------------------------
// A set, kill, restart or poll answers with one status transaction, registered
// out of the execute state; busy is high for one cycle in between. A new command
// is taken only once busy has dropped. A tick holds busy through its sweep and the
// drain state, because the single timer memory is swept one entry per cycle.
// Expiry events appear during the sweep; the final one can follow just after it.
// Reset: a per-entry valid bit clears at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------

module software_timer_bank #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stb_pkg::req_type req_item,
   output logic             rsp_valid,
   output stb_pkg::rsp_type rsp_item
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   // The timer memory. Entries never written since reset read as all zero, which
   // is exactly the reset state of a timer, so the valid bits stand in for a clear.
   stb_pkg::tmr_entry_type mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  vld_ff;

   stb_pkg::tmr_entry_type rd_data_ff;
   logic                   rd_vld_ff;
   logic [IDX_W-1:0]       rd_addr;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   stb_pkg::tmr_entry_type wr_data;

   // Control and registered outputs.
   state_type                      state_ff,    state_in;
   logic                           busy_ff,     busy_in;
   stb_pkg::req_type               req_ff,      req_in;
   logic [IDX_W-1:0]               proc_ff,     proc_in;
   logic [stb_pkg::RSP_CNT_W-1:0]  cnt_ff,      cnt_in;
   stb_pkg::rsp_type               pend_ff,     pend_in;
   logic                           pend_vld_ff, pend_vld_in;
   stb_pkg::rsp_type               rsp_ff,      rsp_in;
   logic                           rsp_vld_ff,  rsp_vld_in;

   stb_pkg::tmr_entry_type ent;
   stb_pkg::tmr_entry_type cmd_ent;
   stb_pkg::tmr_entry_type tick_ent;
   logic                   cmd_ok;
   logic [4:0]             cmd_which;
   logic [15:0]            amt_eff;
   logic [32:0]            tick_sum;
   logic                   tick_upd;
   logic                   tick_hit;
   logic                   tick_ev;
   logic                   sweep_last;

   function automatic logic chan_valid(input logic [4:0] ch);
      return (ch != 5'd0) && (32'(ch) <= NUM_TIMERS);
   endfunction

   function automatic logic [IDX_W-1:0] chan_index(input logic [4:0] ch);
      logic [31:0] wide;
      wide = 32'(ch) - 32'd1;
      return chan_valid(ch) ? IDX_W'(wide) : '0;
   endfunction

   // Read port: one registered read per cycle.
   always_comb begin
      rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_item.opcode != stb_pkg::OP_TICK) begin
               rd_addr = chan_index(req_item.channel);
            end
         end
         ST_SWEEP: begin
            // The last entry of the sweep needs no look-ahead read.
            if (!sweep_last) begin
               rd_addr = IDX_W'(32'(proc_ff) + 32'd1);
            end
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // The entry that was read in the previous cycle. A tick's sweep reads entry
   // i + 1 while it writes entry i back, and a command's single write lands before
   // the next transaction can be accepted, so no forwarding is needed.
   assign ent = rd_vld_ff ? rd_data_ff : '0;

   // Command update of one entry.
   always_comb begin
      cmd_ent   = ent;
      cmd_ok    = 1'b0;
      cmd_which = req_ff.channel;
      case (req_ff.opcode)
         stb_pkg::OP_SET: begin
            if (chan_valid(req_ff.channel) && (req_ff.period != 32'd0)) begin
               cmd_ent.active  = 1'b1;
               cmd_ent.timeout = req_ff.period;
               cmd_ent.handler = req_ff.has_handler;
               cmd_ok          = 1'b1;
            end else begin
               cmd_which = 5'd0;
            end
         end
         stb_pkg::OP_KILL: begin
            if (chan_valid(req_ff.channel)) begin
               cmd_ent.timeout = 32'd0;
               cmd_ent.elapsed = 32'd0;
               cmd_ent.flag    = 1'b0;
               if (ent.active) begin
                  cmd_ent.active  = 1'b0;
                  cmd_ent.handler = 1'b0;
                  cmd_ok          = 1'b1;
               end
            end
         end
         stb_pkg::OP_RESTART: begin
            if (chan_valid(req_ff.channel) && ent.active) begin
               cmd_ent.elapsed = 32'd0;
               cmd_ok          = 1'b1;
            end
         end
         stb_pkg::OP_POLL: begin
            if (chan_valid(req_ff.channel) && ent.active && ent.flag) begin
               cmd_ent.flag = 1'b0;
               cmd_ok       = 1'b1;
            end
         end
         default: begin
            // Unknown codes leave the entry as it is and answer with a failure.
            cmd_which = 5'd0;
         end
      endcase
   end

   // Tick update of one entry. The sum is one bit wider than the count, so a large
   // amount on a count near its limit still compares correctly against the period.
   assign amt_eff  = (req_ff.tick_amount == 16'd0) ? stb_pkg::TICK_DEFAULT
                                                   : req_ff.tick_amount;
   assign tick_upd = ent.active && (ent.timeout != 32'd0);
   assign tick_sum = {1'b0, ent.elapsed} + 33'(amt_eff);
   assign tick_hit = tick_upd && (tick_sum >= {1'b0, ent.timeout});
   assign tick_ev  = tick_hit && ent.handler &&
                     (cnt_ff < stb_pkg::RSP_CNT_W'(stb_pkg::MAX_RESULTS));
   assign sweep_last = (proc_ff == IDX_W'(NUM_TIMERS - 1));

   always_comb begin
      tick_ent = ent;
      if (tick_hit) begin
         tick_ent.flag    = 1'b1;
         tick_ent.elapsed = 32'd0;
      end else if (tick_upd) begin
         tick_ent.elapsed = tick_sum[31:0];
      end
   end

   // Sequencer. During a sweep one expiry event is held back, because whether it
   // is the last of the run is known only when the next event or the end arrives.
   always_comb begin
      state_in    = state_ff;
      busy_in     = busy_ff;
      req_in      = req_ff;
      proc_in     = proc_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = proc_ff;
      wr_data     = tick_ent;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_item;
               busy_in     = 1'b1;
               proc_in     = '0;
               cnt_in      = '0;
               pend_vld_in = 1'b0;
               state_in    = (req_item.opcode == stb_pkg::OP_TICK) ? ST_SWEEP : ST_EXEC;
            end
         end
         ST_EXEC: begin
            wr_en       = 1'b1;
            wr_addr     = chan_index(req_ff.channel);
            wr_data     = cmd_ent;
            rsp_vld_in  = 1'b1;
            rsp_in      = '{reply_kind:  stb_pkg::RSP_STATUS,
                            success:     cmd_ok,
                            which_timer: cmd_which,
                            last_of_run: 1'b1};
            busy_in     = 1'b0;
            state_in    = ST_IDLE;
         end
         ST_SWEEP: begin
            wr_en = 1'b1;
            if (tick_ev) begin
               if (pend_vld_ff) begin
                  rsp_vld_in = 1'b1;
                  rsp_in     = pend_ff;
               end
               pend_in     = '{reply_kind:  stb_pkg::RSP_EVENT,
                               success:     1'b1,
                               which_timer: 5'(32'(proc_ff) + 32'd1),
                               last_of_run: 1'b0};
               pend_vld_in = 1'b1;
               cnt_in      = cnt_ff + stb_pkg::RSP_CNT_W'(1);
            end
            proc_in = IDX_W'(32'(proc_ff) + 32'd1);
            if (sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pend_vld_ff) begin
               rsp_vld_in = 1'b1;
               rsp_in     = pend_ff;
               rsp_in.last_of_run = 1'b1;
            end
            pend_vld_in = 1'b0;
            busy_in     = 1'b0;
            state_in    = ST_IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         busy_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         cnt_ff      <= '0;
         proc_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         busy_ff     <= busy_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         cnt_ff      <= cnt_in;
         proc_ff     <= proc_in;
      end
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ sv/stb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank checker
// Port-level assertions on the command and result transactions.
// ----------------------------------------------------------------------------

`include "software_timer_bank_macros.svh"

module stb_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input stb_pkg::rsp_type rsp_item
);

   logic status_rsp;
   logic event_rsp;

   assign status_rsp = rsp_valid && (rsp_item.reply_kind == stb_pkg::RSP_STATUS);
   assign event_rsp  = rsp_valid && (rsp_item.reply_kind == stb_pkg::RSP_EVENT);

   // An accepted transaction keeps the bank busy in the following cycle.
   `STB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // A command answers with exactly one status, so it always closes the run.
   `STB_ASSERT_SAME(a_status_last, clock, reset, status_rsp, rsp_item.last_of_run, "not last")

   // Expiry events always report success.
   `STB_ASSERT_SAME(a_event_ok, clock, reset, event_rsp, rsp_item.success, "event failed")

   // A status follows the single busy cycle of its command.
   `STB_ASSERT_SAME(a_status_busy, clock, reset, status_rsp, $past(busy) && !busy, "timing")

endmodule

bind software_timer_bank stb_checker u_stb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives tick, set, kill, restart and poll commands into the timer bank. It
// predicts every status and expiry transaction with its own model of the
// sixteen timers and checks each one as it appears, field by field.
// ----------------------------------------------------------------------------

module tb_top;

   // Opcodes above poll are undefined. The block must answer them with a
   // failed status and leave every timer as it was.
   localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

   localparam int ITEM_TARGET = 310;
   localparam int SETTLE_CYCLES = stb_pkg::NUM_TIMERS_DEF + 8;

   // -------------------------------------------------------------------------
   // Scoreboard. It keeps its own copy of every timer entry. Each accepted
   // command is applied to that copy, and the transactions that the command
   // should produce are queued in order. Each transaction from the block is
   // then compared with the oldest entry in the queue.
   // -------------------------------------------------------------------------
   class timer_bank_checker;
      bit               armed   [stb_pkg::NUM_TIMERS_DEF];
      bit               notify  [stb_pkg::NUM_TIMERS_DEF];
      bit               expired [stb_pkg::NUM_TIMERS_DEF];
      logic [31:0]      count   [stb_pkg::NUM_TIMERS_DEF];
      logic [31:0]      limit   [stb_pkg::NUM_TIMERS_DEF];
      stb_pkg::rsp_type replies_due[$];
      int               failures;

      function new();
         for (int i = 0; i < stb_pkg::NUM_TIMERS_DEF; i++) begin
            armed[i]   = 1'b0;
            notify[i]  = 1'b0;
            expired[i] = 1'b0;
            count[i]   = '0;
            limit[i]   = '0;
         end
         failures = 0;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      // Applies one accepted command to the timer copy and queues the
      // transactions that it should produce.
      function void note_command(stb_pkg::req_type cmd);
         stb_pkg::rsp_type status;
         stb_pkg::rsp_type fired[$];
         logic [32:0]      total;
         logic [15:0]      step;
         bit               in_range;
         int               idx;

         in_range = (cmd.channel >= 5'd1) && (cmd.channel <= stb_pkg::NUM_TIMERS_DEF);
         idx = in_range ? int'(cmd.channel) - 1 : 0;

         if (cmd.opcode == stb_pkg::OP_TICK) begin
            // The sum is one bit wider than the count, so it cannot wrap.
            step = (cmd.tick_amount == '0) ? stb_pkg::TICK_DEFAULT : cmd.tick_amount;
            for (int i = 0; i < stb_pkg::NUM_TIMERS_DEF; i++) begin
               if (armed[i] && limit[i] != '0) begin
                  total = {1'b0, count[i]} + {17'd0, step};
                  if (total >= {1'b0, limit[i]}) begin
                     expired[i] = 1'b1;
                     count[i] = '0;
                     if (notify[i] && fired.size() < stb_pkg::MAX_RESULTS) begin
                        status.reply_kind  = stb_pkg::RSP_EVENT;
                        status.success     = 1'b1;
                        status.which_timer = 5'(i + 1);
                        status.last_of_run = 1'b0;
                        fired.push_back(status);
                     end
                  end else begin
                     count[i] = total[31:0];
                  end
               end
            end
            // A tick with no expiring handler gives no transaction at all.
            if (fired.size() > 0) begin
               fired[fired.size() - 1].last_of_run = 1'b1;
            end
            foreach (fired[k]) replies_due.push_back(fired[k]);
            return;
         end

         status.reply_kind  = stb_pkg::RSP_STATUS;
         status.success     = 1'b0;
         status.which_timer = cmd.channel;
         status.last_of_run = 1'b1;

         case (cmd.opcode)
            stb_pkg::OP_SET: begin
               // Set leaves the count and the flag alone.
               if (in_range && cmd.period != '0) begin
                  armed[idx]  = 1'b1;
                  limit[idx]  = cmd.period;
                  notify[idx] = cmd.has_handler;
                  status.success = 1'b1;
               end else begin
                  status.which_timer = '0;
               end
            end
            stb_pkg::OP_KILL: begin
               if (in_range) begin
                  limit[idx]   = '0;
                  count[idx]   = '0;
                  expired[idx] = 1'b0;
                  if (armed[idx]) begin
                     armed[idx]  = 1'b0;
                     notify[idx] = 1'b0;
                     status.success = 1'b1;
                  end
               end
            end
            stb_pkg::OP_RESTART: begin
               if (in_range && armed[idx]) begin
                  count[idx] = '0;
                  status.success = 1'b1;
               end
            end
            stb_pkg::OP_POLL: begin
               if (in_range && armed[idx] && expired[idx]) begin
                  expired[idx] = 1'b0;
                  status.success = 1'b1;
               end
            end
            default: begin
               status.which_timer = '0;
            end
         endcase
         replies_due.push_back(status);
      endfunction

      // Compares one transaction from the block with the oldest prediction.
      function void check_reply(stb_pkg::rsp_type got);
         stb_pkg::rsp_type want;

         if (replies_due.size() == 0) begin
            $error("unexpected transaction: kind %0d success %0d timer %0d last %0d",
                   got.reply_kind, got.success, got.which_timer, got.last_of_run);
            failures++;
            return;
         end
         want = replies_due.pop_front();
         if (got.reply_kind !== want.reply_kind) begin
            $error("reply_kind: expected %0d, actual %0d", want.reply_kind, got.reply_kind);
            failures++;
         end
         if (got.success !== want.success) begin
            $error("success: expected %0d, actual %0d", want.success, got.success);
            failures++;
         end
         if (got.which_timer !== want.which_timer) begin
            $error("which_timer: expected %0d, actual %0d",
                   want.which_timer, got.which_timer);
            failures++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d",
                   want.last_of_run, got.last_of_run);
            failures++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block itself.
   // -------------------------------------------------------------------------
   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   stb_pkg::req_type req_item;
   logic             rsp_valid;
   stb_pkg::rsp_type rsp_item;

   timer_bank_checker chk;
   int                items_sent;
   int                burst_left;

   software_timer_bank uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;

   always #6 clock = ~clock;

   // -------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, before the block's own
   // registers update, so a command is taken as accepted exactly when the
   // block saw start high and busy low. A result for a command can never
   // appear at the edge that accepts it, so checking first and noting second
   // keeps the queue in order.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) chk.check_reply(rsp_item);
         if (start && !busy) chk.note_command(req_item);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   function automatic stb_pkg::req_type make_cmd(logic [2:0] op, logic [4:0] ch,
                                                 logic [15:0] amt, logic [31:0] per,
                                                 logic hnd);
      stb_pkg::req_type cmd;

      cmd.opcode      = op;
      cmd.channel     = ch;
      cmd.tick_amount = amt;
      cmd.period      = per;
      cmd.has_handler = hnd;
      return cmd;
   endfunction

   // Mostly valid channels and short periods, so that timers really expire,
   // with a share of out-of-range channels, zero and full-width periods and
   // undefined opcodes as noise.
   function automatic stb_pkg::req_type random_command();
      stb_pkg::req_type cmd;
      int               pick;

      pick = $urandom_range(0, 99);
      cmd.channel     = ($urandom_range(0, 9) == 0) ?
                        5'($urandom_range(0, 31)) :
                        5'($urandom_range(1, stb_pkg::NUM_TIMERS_DEF));
      cmd.tick_amount = 16'($urandom_range(0, 65535));
      cmd.period      = $urandom();
      cmd.has_handler = 1'($urandom_range(0, 1));

      if (pick < 35) begin
         cmd.opcode = stb_pkg::OP_TICK;
         if ($urandom_range(0, 9) != 0) cmd.tick_amount = 16'($urandom_range(0, 40));
      end else if (pick < 55) begin
         cmd.opcode = stb_pkg::OP_SET;
         case ($urandom_range(0, 9))
            0:       cmd.period = '0;
            1, 2:    cmd.period = $urandom();
            default: cmd.period = 32'($urandom_range(1, 60));
         endcase
      end else if (pick < 65) begin
         cmd.opcode = stb_pkg::OP_KILL;
      end else if (pick < 76) begin
         cmd.opcode = stb_pkg::OP_RESTART;
      end else if (pick < 94) begin
         cmd.opcode = stb_pkg::OP_POLL;
      end else begin
         cmd.opcode = 3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
      end
      return cmd;
   endfunction

   // Presents one command and holds it until the block takes it. The sender
   // works in bursts: once a burst is used up a random gap follows, and now
   // and then a long burst runs with no gaps at all.
   task automatic issue(input stb_pkg::req_type cmd);
      int gap;

      req_item <= cmd;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Arms every timer with a short period, mostly with handlers, and then
   // ticks a few times, so that ticks produce long runs of expiry events.
   task automatic arm_whole_bank();
      for (int ch = 1; ch <= stb_pkg::NUM_TIMERS_DEF; ch++) begin
         issue(make_cmd(stb_pkg::OP_SET, 5'(ch), 16'($urandom()),
                        32'($urandom_range(1, 25)), 1'($urandom_range(0, 3) != 0)));
      end
      repeat (4) begin
         issue(make_cmd(stb_pkg::OP_TICK, 5'($urandom()), 16'($urandom_range(0, 30)),
                        $urandom(), 1'($urandom())));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      bit drained;

      chk = new();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      items_sent = 0;
      burst_left = 4;
      drained = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the default tick amount, the full tick amount, a flag
      // set without a handler, channel zero and channels past the bank, a
      // zero period, the full period, commands on idle timers, re-arming a
      // running timer and the undefined opcodes.
      issue(make_cmd(stb_pkg::OP_SET,     5'd1,  16'd0,    32'd10,        1'b1));
      issue(make_cmd(stb_pkg::OP_TICK,    5'd0,  16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_POLL,    5'd1,  16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_POLL,    5'd1,  16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_SET,     5'd16, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      issue(make_cmd(stb_pkg::OP_SET,     5'd2,  16'd0,    32'd65535,     1'b0));
      issue(make_cmd(stb_pkg::OP_TICK,    5'd31, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      issue(make_cmd(stb_pkg::OP_POLL,    5'd2,  16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_SET,     5'd0,  16'd0,    32'd5,         1'b1));
      issue(make_cmd(stb_pkg::OP_SET,     5'd17, 16'd0,    32'd5,         1'b1));
      issue(make_cmd(stb_pkg::OP_SET,     5'd31, 16'd0,    32'd5,         1'b0));
      issue(make_cmd(stb_pkg::OP_SET,     5'd3,  16'd0,    32'd0,         1'b1));
      issue(make_cmd(stb_pkg::OP_KILL,    5'd0,  16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_KILL,    5'd31, 16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_KILL,    5'd4,  16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_RESTART, 5'd5,  16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_RESTART, 5'd16, 16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_RESTART, 5'd31, 16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_POLL,    5'd0,  16'd0,    32'd0,         1'b0));
      issue(make_cmd(stb_pkg::OP_KILL,    5'd16, 16'd0,    32'd0,         1'b0));
      issue(make_cmd(OP_UNDEF_FIRST,      5'd1,  16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      issue(make_cmd(OP_UNDEF_FIRST + 1,  5'd9,  16'd1,    32'd1,         1'b0));
      issue(make_cmd(OP_UNDEF_LAST,       5'd0,  16'd0,    32'd0,         1'b1));
      issue(make_cmd(stb_pkg::OP_SET,     5'd1,  16'd0,    32'd12,        1'b1));
      issue(make_cmd(stb_pkg::OP_TICK,    5'd0,  16'd1,    32'd0,         1'b0));

      // Random part, with the whole bank re-armed now and then.
      while (items_sent < ITEM_TARGET) begin
         if (items_sent % 70 == 40) begin
            arm_whole_bank();
         end else begin
            issue(random_command());
         end
         // Once, part of the way through, the sender holds off until the
         // block has delivered every transaction it owes.
         if (!drained && items_sent >= ITEM_TARGET / 2) begin
            drained = 1'b1;
            start <= 1'b0;
            do @(posedge clock); while (chk.pending() != 0);
         end
      end
      start <= 1'b0;

      // Wait for the last transactions, then give a tick time to finish its
      // sweep in case something stray follows.
      do @(posedge clock); while (chk.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (chk.pending() != 0) begin
         $error("%0d predicted transactions never arrived", chk.pending());
         chk.failures++;
      end
      if (chk.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
